// ===== src/vkvp_pkg.sv =====
// vkvp_pkg: shared types and constants of the voice key-on volume and pan block
// used by every module under src except vkvp_checker; depends on nothing

package vkvp_pkg;

    // field widths
    localparam int VOL7_W    = 7;
    localparam int VOICE_W   = 5;
    localparam int PITCH_W   = 16;
    localparam int VOL_W     = 14;
    localparam int MASK_W    = 24;
    localparam int MASK_EXT_W = 32;

    // stream word widths
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 104;

    // shared multiplier: 28-bit operand a, 29-bit operand b
    localparam int ACC_W  = 28;
    localparam int RCP_W  = 29;
    localparam int PROD_W = ACC_W + RCP_W;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MASTER_VOLUME = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MONO_MODE     = 1'd1;
    localparam int CFG_DATA_W = 7;

    localparam logic [VOL7_W-1:0] MASTER_RESET = 7'd127;
    localparam logic [VOL7_W-1:0] VOL_MAX      = 7'd127;
    localparam logic [VOL_W-1:0]  FULL_SCALE   = 14'd16383;

    // constant divisors
    localparam longint DIV_VOL_SQ  = 16129;
    localparam longint DIV_VOL_MAX = 127;
    localparam longint DIV_PAN     = 63;
    localparam longint DIV_FULL    = 16383;

    // shift = 28 + ceil(log2(divisor)) keeps the reciprocal exact for any 28-bit numerator
    localparam int SH_VOL_SQ  = 42;
    localparam int SH_VOL_MAX = 35;
    localparam int SH_PAN     = 34;
    localparam int SH_FULL    = 42;

    localparam logic [RCP_W-1:0] RCP_VOL_SQ =
        RCP_W'(((64'd1 << SH_VOL_SQ) + DIV_VOL_SQ - 1) / DIV_VOL_SQ);
    localparam logic [RCP_W-1:0] RCP_VOL_MAX =
        RCP_W'(((64'd1 << SH_VOL_MAX) + DIV_VOL_MAX - 1) / DIV_VOL_MAX);
    localparam logic [RCP_W-1:0] RCP_PAN =
        RCP_W'(((64'd1 << SH_PAN) + DIV_PAN - 1) / DIV_PAN);
    localparam logic [RCP_W-1:0] RCP_FULL =
        RCP_W'(((64'd1 << SH_FULL) + DIV_FULL - 1) / DIV_FULL);

    // divisor select codes
    localparam logic [1:0] DSEL_VOL_SQ  = 2'd0;
    localparam logic [1:0] DSEL_VOL_MAX = 2'd1;
    localparam logic [1:0] DSEL_PAN     = 2'd2;
    localparam logic [1:0] DSEL_FULL    = 2'd3;

    typedef struct packed {
        logic [VOL7_W-1:0]  note_volume;
        logic [VOL7_W-1:0]  program_volume;
        logic [VOL7_W-1:0]  tone_volume;
        logic [VOL7_W-1:0]  seq_left_volume;
        logic [VOL7_W-1:0]  seq_right_volume;
        logic               seq_scaling_on;
        logic [VOL7_W-1:0]  timbre_pan;
        logic [VOL7_W-1:0]  program_pan;
        logic [VOL7_W-1:0]  note_pan;
        logic [VOICE_W-1:0] voice_number;
        logic [PITCH_W-1:0] pitch_word;
        logic               reverb_on;
    } vkvp_item_t;

    typedef struct packed {
        logic [VOICE_W-1:0] voice;
        logic [PITCH_W-1:0] pitch;
        logic               reverb_on;
        logic [VOL_W-1:0]   left;
        logic [VOL_W-1:0]   right;
    } vkvp_res_t;

    // one operation of the shared multiplier
    typedef struct packed {
        logic             en;
        logic             div_en;
        logic [1:0]       dsel;
        logic [ACC_W-1:0] a;
        logic [RCP_W-1:0] b;
    } vkvp_mul_op_t;

    typedef struct packed {
        logic busy;
        logic done;
    } vkvp_stat_t;

endpackage

// ===== src/vkvp_mul_unit.sv =====
// vkvp_mul_unit: shared multiplier with constant division by reciprocal multiply
// depends on vkvp_pkg

module vkvp_mul_unit
    import vkvp_pkg::*;
(
    input  logic             aclk,
    input  vkvp_mul_op_t     op,
    output logic [ACC_W-1:0] acc
);

    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] quot;
    logic [ACC_W-1:0]  acc_next;
    logic [ACC_W-1:0]  acc_reg;

    // product, then shift for the divide case
    always_comb begin
        prod = PROD_W'(op.a) * PROD_W'(op.b);
        case (op.dsel)
            DSEL_VOL_SQ:  quot = prod >> SH_VOL_SQ;
            DSEL_VOL_MAX: quot = prod >> SH_VOL_MAX;
            DSEL_PAN:     quot = prod >> SH_PAN;
            DSEL_FULL:    quot = prod >> SH_FULL;
            default:      quot = prod >> SH_FULL;
        endcase
        acc_next = op.div_en ? quot[ACC_W-1:0] : prod[ACC_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (op.en) begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

// ===== src/vkvp_ctrl.sv =====
// vkvp_ctrl: step sequencer that drives the shared multiplier and keeps left/right
// depends on vkvp_pkg

module vkvp_ctrl
    import vkvp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic              take,
    input  vkvp_item_t        item,
    input  logic [VOL7_W-1:0] master_volume,
    input  logic              mono_mode,
    input  logic [ACC_W-1:0]  acc,
    output vkvp_mul_op_t      mul_op,
    output vkvp_stat_t        stat,
    output vkvp_res_t         res
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] STEP_NOTE_MASTER = 5'd0;
    localparam logic [STEP_W-1:0] STEP_FULL_SCALE  = 5'd1;
    localparam logic [STEP_W-1:0] STEP_DIV_BASE1   = 5'd2;
    localparam logic [STEP_W-1:0] STEP_PROG_VOL    = 5'd3;
    localparam logic [STEP_W-1:0] STEP_TONE_VOL    = 5'd4;
    localparam logic [STEP_W-1:0] STEP_DIV_BASE2   = 5'd5;
    localparam logic [STEP_W-1:0] STEP_SEQ_LEFT    = 5'd6;
    localparam logic [STEP_W-1:0] STEP_DIV_SEQ_L   = 5'd7;
    localparam logic [STEP_W-1:0] STEP_SEQ_RIGHT   = 5'd8;
    localparam logic [STEP_W-1:0] STEP_DIV_SEQ_R   = 5'd9;
    localparam logic [STEP_W-1:0] STEP_SEQ_WB      = 5'd10;
    localparam logic [STEP_W-1:0] STEP_TP_MUL      = 5'd11;
    localparam logic [STEP_W-1:0] STEP_TP_DIV      = 5'd12;
    localparam logic [STEP_W-1:0] STEP_TP_WB       = 5'd13;
    localparam logic [STEP_W-1:0] STEP_PP_MUL      = 5'd14;
    localparam logic [STEP_W-1:0] STEP_PP_DIV      = 5'd15;
    localparam logic [STEP_W-1:0] STEP_PP_WB       = 5'd16;
    localparam logic [STEP_W-1:0] STEP_NP_MUL      = 5'd17;
    localparam logic [STEP_W-1:0] STEP_NP_DIV      = 5'd18;
    localparam logic [STEP_W-1:0] STEP_NP_WB       = 5'd19;
    localparam logic [STEP_W-1:0] STEP_MONO        = 5'd20;
    localparam logic [STEP_W-1:0] STEP_SQ_LEFT     = 5'd21;
    localparam logic [STEP_W-1:0] STEP_DIV_SQ_L    = 5'd22;
    localparam logic [STEP_W-1:0] STEP_SQ_RIGHT    = 5'd23;
    localparam logic [STEP_W-1:0] STEP_DIV_SQ_R    = 5'd24;
    localparam logic [STEP_W-1:0] STEP_SQ_WB       = 5'd25;
    localparam logic [STEP_W-1:0] STEP_OUT         = 5'd26;

    logic              state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    vkvp_item_t        item_reg;
    logic [VOL_W-1:0]  lv_reg, lv_next;
    logic [VOL_W-1:0]  rv_reg, rv_next;
    logic [VOL_W-1:0]  acc_vol;
    logic [VOL7_W-1:0] pan_val;
    logic              pan_right;
    logic [VOL7_W-1:0] pan_coef;

    assign acc_vol = acc[VOL_W-1:0];

    // pan of the current stage: below 64 scales right, else scales left
    always_comb begin
        if (step_reg <= STEP_TP_WB) begin
            pan_val = item_reg.timbre_pan;
        end else if (step_reg <= STEP_PP_WB) begin
            pan_val = item_reg.program_pan;
        end else begin
            pan_val = item_reg.note_pan;
        end
        pan_right = ~pan_val[VOL7_W-1];
        pan_coef  = pan_right ? pan_val : VOL7_W'(VOL_MAX - pan_val);
    end

    // step decode: multiplier operation and left/right write-back
    always_comb begin
        mul_op.en     = 1'b0;
        mul_op.div_en = 1'b0;
        mul_op.dsel   = DSEL_VOL_SQ;
        mul_op.a      = acc;
        mul_op.b      = '0;
        lv_next       = lv_reg;
        rv_next       = rv_reg;
        if (state_reg == ST_RUN) begin
            case (step_reg)
                STEP_NOTE_MASTER: begin
                    mul_op.en = 1'b1;
                    mul_op.a  = ACC_W'(item_reg.note_volume);
                    mul_op.b  = RCP_W'(master_volume);
                end
                STEP_FULL_SCALE: begin
                    mul_op.en = 1'b1;
                    mul_op.b  = RCP_W'(FULL_SCALE);
                end
                STEP_DIV_BASE1, STEP_DIV_BASE2: begin
                    mul_op.en     = 1'b1;
                    mul_op.div_en = 1'b1;
                    mul_op.dsel   = DSEL_VOL_SQ;
                    mul_op.b      = RCP_VOL_SQ;
                end
                STEP_PROG_VOL: begin
                    mul_op.en = 1'b1;
                    mul_op.b  = RCP_W'(item_reg.program_volume);
                end
                STEP_TONE_VOL: begin
                    mul_op.en = 1'b1;
                    mul_op.b  = RCP_W'(item_reg.tone_volume);
                end
                STEP_SEQ_LEFT: begin
                    // acc holds the base level here
                    lv_next   = acc_vol;
                    rv_next   = acc_vol;
                    mul_op.en = 1'b1;
                    mul_op.b  = RCP_W'(item_reg.seq_left_volume);
                end
                STEP_DIV_SEQ_L, STEP_DIV_SEQ_R: begin
                    mul_op.en     = 1'b1;
                    mul_op.div_en = 1'b1;
                    mul_op.dsel   = DSEL_VOL_MAX;
                    mul_op.b      = RCP_VOL_MAX;
                end
                STEP_SEQ_RIGHT: begin
                    if (item_reg.seq_scaling_on) begin
                        lv_next = acc_vol;
                    end
                    mul_op.en = 1'b1;
                    mul_op.a  = ACC_W'(rv_reg);
                    mul_op.b  = RCP_W'(item_reg.seq_right_volume);
                end
                STEP_SEQ_WB: begin
                    if (item_reg.seq_scaling_on) begin
                        rv_next = acc_vol;
                    end
                end
                STEP_TP_MUL, STEP_PP_MUL, STEP_NP_MUL: begin
                    mul_op.en = 1'b1;
                    mul_op.a  = pan_right ? ACC_W'(rv_reg) : ACC_W'(lv_reg);
                    mul_op.b  = RCP_W'(pan_coef);
                end
                STEP_TP_DIV, STEP_PP_DIV, STEP_NP_DIV: begin
                    mul_op.en     = 1'b1;
                    mul_op.div_en = 1'b1;
                    mul_op.dsel   = DSEL_PAN;
                    mul_op.b      = RCP_PAN;
                end
                STEP_TP_WB, STEP_PP_WB, STEP_NP_WB: begin
                    if (pan_right) begin
                        rv_next = acc_vol;
                    end else begin
                        lv_next = acc_vol;
                    end
                end
                STEP_MONO: begin
                    if (mono_mode) begin
                        if (lv_reg < rv_reg) begin
                            lv_next = rv_reg;
                        end else begin
                            rv_next = lv_reg;
                        end
                    end
                end
                STEP_SQ_LEFT: begin
                    mul_op.en = 1'b1;
                    mul_op.a  = ACC_W'(lv_reg);
                    mul_op.b  = RCP_W'(lv_reg);
                end
                STEP_DIV_SQ_L, STEP_DIV_SQ_R: begin
                    mul_op.en     = 1'b1;
                    mul_op.div_en = 1'b1;
                    mul_op.dsel   = DSEL_FULL;
                    mul_op.b      = RCP_FULL;
                end
                STEP_SQ_RIGHT: begin
                    lv_next   = acc_vol;
                    mul_op.en = 1'b1;
                    mul_op.a  = ACC_W'(rv_reg);
                    mul_op.b  = RCP_W'(rv_reg);
                end
                STEP_SQ_WB: begin
                    rv_next = acc_vol;
                end
                default: begin
                    // hold until the output register takes the word
                end
            endcase
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_RUN;
                    step_next  = STEP_NOTE_MASTER;
                end
            end
            ST_RUN: begin
                if (step_reg != STEP_OUT) begin
                    step_next = step_reg + STEP_W'(1);
                end else if (take) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= STEP_NOTE_MASTER;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && start) begin
            item_reg <= item;
        end
        lv_reg <= lv_next;
        rv_reg <= rv_next;
    end

    assign stat.busy = (state_reg == ST_RUN);
    assign stat.done = (state_reg == ST_RUN) && (step_reg == STEP_OUT);

    assign res.voice     = item_reg.voice_number;
    assign res.pitch     = item_reg.pitch_word;
    assign res.reverb_on = item_reg.reverb_on;
    assign res.left      = lv_reg;
    assign res.right     = rv_reg;

endmodule

// ===== src/voice_keyon_volume_pan.sv =====
// voice_keyon_volume_pan: top level with stream ports, config registers, voice masks
// depends on vkvp_pkg, vkvp_ctrl and vkvp_mul_unit
//
//  channel  | direction | handshake          | contents
//  s_       | in        | s_tvalid/s_tready  | one note-on event per word
//  m_       | out       | m_tvalid/m_tready  | voice, volumes, pitch, masks
//  cfg_     | in        | cfg_wr_en          | master_volume (0), mono_mode (1)
//
// an event runs through the 27 steps of the sequencer around the single shared
// multiplier; the input takes no new word while an event is in work and reopens
// when that event's result word is registered
// aresetn is synchronous and active low; it clears masks and sets master volume to 127
// while the result word is stalled the sequencer holds in its last step

module voice_keyon_volume_pan
    import vkvp_pkg::*;
#(
    parameter int VOICES = 24
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // note_volume, program_volume, tone_volume, seq_left_volume, seq_right_volume,
    // seq_scaling_on, timbre_pan, program_pan, note_pan, voice_number, pitch_word,
    // reverb_on, zero fill
    input  logic [S_TDATA_W-1:0]   s_tdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // voice_out, left_volume, right_volume, pitch_out, key_on_mask, reverb_mask,
    // zero fill
    output logic [M_TDATA_W-1:0]   m_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    vkvp_item_t          item;
    vkvp_mul_op_t        mul_op;
    vkvp_stat_t          stat;
    vkvp_res_t           res;
    logic [ACC_W-1:0]    acc;
    logic                start;
    logic                take;
    logic [VOL7_W-1:0]   master_reg;
    logic                mono_reg;
    logic [VOICES-1:0]   key_reg, key_next;
    logic [VOICES-1:0]   rev_reg, rev_next;
    logic [MASK_EXT_W-1:0] key_ext;
    logic [MASK_EXT_W-1:0] rev_ext;
    logic [M_TDATA_W-1:0]  m_tdata_reg;
    logic                  m_tvalid_reg;

    // input word unpacking
    assign item.note_volume      = s_tdata[6:0];
    assign item.program_volume   = s_tdata[13:7];
    assign item.tone_volume      = s_tdata[20:14];
    assign item.seq_left_volume  = s_tdata[27:21];
    assign item.seq_right_volume = s_tdata[34:28];
    assign item.seq_scaling_on   = s_tdata[35];
    assign item.timbre_pan       = s_tdata[42:36];
    assign item.program_pan      = s_tdata[49:43];
    assign item.note_pan         = s_tdata[56:50];
    assign item.voice_number     = s_tdata[61:57];
    assign item.pitch_word       = s_tdata[77:62];
    assign item.reverb_on        = s_tdata[78];

    assign s_tready = ~stat.busy;
    assign start    = s_tvalid & ~stat.busy;
    assign take     = stat.done & (~m_tvalid_reg | m_tready);

    vkvp_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .start         (start),
        .take          (take),
        .item          (item),
        .master_volume (master_reg),
        .mono_mode     (mono_reg),
        .acc           (acc),
        .mul_op        (mul_op),
        .stat          (stat),
        .res           (res)
    );

    vkvp_mul_unit u_mul (
        .aclk (aclk),
        .op   (mul_op),
        .acc  (acc)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            master_reg <= MASTER_RESET;
            mono_reg   <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_MASTER_VOLUME: master_reg <= cfg_wdata;
                CFG_MONO_MODE:     mono_reg   <= cfg_wdata[0];
                default:           master_reg <= master_reg;
            endcase
        end
    end

    // key-on and reverb bits of the event's voice; out-of-range voices match nothing
    always_comb begin
        for (int i = 0; i < VOICES; i++) begin
            if (res.voice == VOICE_W'(i)) begin
                key_next[i] = 1'b1;
                rev_next[i] = res.reverb_on;
            end else begin
                key_next[i] = key_reg[i];
                rev_next[i] = rev_reg[i];
            end
        end
    end

    assign key_ext = MASK_EXT_W'(key_next);
    assign rev_ext = MASK_EXT_W'(rev_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
            rev_reg <= '0;
        end else if (take) begin
            key_reg <= key_next;
            rev_reg <= rev_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (take) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            m_tdata_reg <= {7'd0, rev_ext[MASK_W-1:0], key_ext[MASK_W-1:0],
                            res.pitch, res.right, res.left, res.voice};
        end
    end

    assign m_tdata  = m_tdata_reg;
    assign m_tvalid = m_tvalid_reg;

endmodule

// ===== src/vkvp_checker.sv =====
// vkvp_checker: port-level assertions for voice_keyon_volume_pan, bound to the top
// depends only on the top level's ports

module vkvp_checker #(
    parameter int VOICES = 24
) (
    input logic         aclk,
    input logic         aresetn,
    input logic [79:0]  s_tdata,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [103:0] m_tdata,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic         cfg_wr_en,
    input logic [0:0]   cfg_index,
    input logic [6:0]   cfg_wdata
);

    // no result word right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result word valid after reset");

    // a stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed");

    // an accepted event keeps the input closed while it is worked on
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
        else $error("input reopened during an event");

    // the shown voice has its key-on bit set
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[4:0] < VOICES) && (m_tdata[4:0] < 5'd24)
        |-> ((m_tdata[72:49] >> m_tdata[4:0]) & 24'd1) != 24'd0)
        else $error("key-on bit of the event's voice not set");

    // no event is accepted while the previous result is being formed
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!(s_tvalid && s_tready)))
        else $error("event accepted in the cycle before its result");

endmodule

bind voice_keyon_volume_pan vkvp_checker #(.VOICES(VOICES)) u_vkvp_checker (.*);

// ===== test/tb_top.sv =====
// tb_top: stream testbench for voice_keyon_volume_pan with its own volume/pan predictor
// depends on vkvp_pkg and voice_keyon_volume_pan from src

`timescale 1ns / 1ps

module tb_top;
    import vkvp_pkg::*;

    localparam int NUM_VOICES   = 24;
    localparam int PAN_CENTER   = 64;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int REPORT_LIMIT = 10;
    localparam int TAIL_CYCLES  = 40;

    // one note-on event as the sender sees it
    typedef struct packed {
        logic [6:0]  note_volume;
        logic [6:0]  program_volume;
        logic [6:0]  tone_volume;
        logic [6:0]  seq_left_volume;
        logic [6:0]  seq_right_volume;
        logic        seq_scaling_on;
        logic [6:0]  timbre_pan;
        logic [6:0]  program_pan;
        logic [6:0]  note_pan;
        logic [4:0]  voice_number;
        logic [15:0] pitch_word;
        logic        reverb_on;
    } keyon_event_t;

    // register values written for one voice
    typedef struct packed {
        logic [4:0]  voice;
        logic [13:0] left;
        logic [13:0] right;
        logic [15:0] pitch;
        logic [23:0] key_on_mask;
        logic [23:0] reverb_mask;
    } voice_regs_t;

    // predicts voice register words and checks them in order
    class keyon_scoreboard;
        logic [6:0]  master_level;
        logic        mono_on;
        logic [23:0] keyon_bits;
        logic [23:0] reverb_bits;
        voice_regs_t pending_q[$];
        int          errors;
        int          events_seen;
        int          words_checked;

        function new();
            master_level  = MASTER_RESET;
            mono_on       = 1'b0;
            keyon_bits    = '0;
            reverb_bits   = '0;
            errors        = 0;
            events_seen   = 0;
            words_checked = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            if (idx == CFG_MASTER_VOLUME)
                master_level = value[6:0];
            else if (idx == CFG_MONO_MODE)
                mono_on = value[0];
        endfunction

        // volume scaling, three pan stages, mono merge, square law, mask update
        function void note_event(keyon_event_t ev);
            longint unsigned base;
            longint unsigned left;
            longint unsigned right;
            logic [6:0]      pans [3];
            voice_regs_t     want;
            base = ev.note_volume;
            base = base * master_level * FULL_SCALE / DIV_VOL_SQ;
            base = base * ev.program_volume * ev.tone_volume / DIV_VOL_SQ;
            left  = base;
            right = base;
            if (ev.seq_scaling_on) begin
                left  = base * ev.seq_left_volume / DIV_VOL_MAX;
                right = base * ev.seq_right_volume / DIV_VOL_MAX;
            end
            // timbre, program, note pan in that order
            pans[0] = ev.timbre_pan;
            pans[1] = ev.program_pan;
            pans[2] = ev.note_pan;
            foreach (pans[i]) begin
                if (pans[i] < PAN_CENTER)
                    right = right * pans[i] / DIV_PAN;
                else
                    left = left * (VOL_MAX - pans[i]) / DIV_PAN;
            end
            if (mono_on) begin
                if (left < right)
                    left = right;
                else
                    right = left;
            end
            left  = left * left / DIV_FULL;
            right = right * right / DIV_FULL;
            // voices beyond the last one leave both masks alone
            if (ev.voice_number < NUM_VOICES) begin
                keyon_bits[ev.voice_number]  = 1'b1;
                reverb_bits[ev.voice_number] = ev.reverb_on;
            end
            want.voice       = ev.voice_number;
            want.left        = left[13:0];
            want.right       = right[13:0];
            want.pitch       = ev.pitch_word;
            want.key_on_mask = keyon_bits;
            want.reverb_mask = reverb_bits;
            pending_q.push_back(want);
            events_seen++;
        endfunction

        function void compare_field(string name, logic [23:0] want, logic [23:0] got);
            if (got !== want) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("mismatch on word %0d, %s: expected 0x%0h, got 0x%0h",
                             words_checked, name, want, got);
            end
        endfunction

        function void check_word(logic [M_TDATA_W-1:0] word);
            voice_regs_t want;
            voice_regs_t got;
            got.voice       = word[4:0];
            got.left        = word[18:5];
            got.right       = word[32:19];
            got.pitch       = word[48:33];
            got.key_on_mask = word[72:49];
            got.reverb_mask = word[96:73];
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("unexpected result word 0x%0h with nothing pending", word);
            end else begin
                want = pending_q.pop_front();
                compare_field("voice_out", 24'(want.voice), 24'(got.voice));
                compare_field("left_volume", 24'(want.left), 24'(got.left));
                compare_field("right_volume", 24'(want.right), 24'(got.right));
                compare_field("pitch_out", 24'(want.pitch), 24'(got.pitch));
                compare_field("key_on_mask", want.key_on_mask, got.key_on_mask);
                compare_field("reverb_mask", want.reverb_mask, got.reverb_mask);
            end
            words_checked++;
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    keyon_scoreboard sb;
    int src_idle_pct;
    int sink_stall_pct;
    int hold_cycles;
    int cycle_count;
    int settings_used;

    voice_keyon_volume_pan #(
        .VOICES(NUM_VOICES)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // run limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("Some tests failed");
        $finish;
    end

    // receiver: random stalls, or a long hold-off when asked
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99, 0) >= sink_stall_pct);
            end
        end
    end

    // result monitor
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                sb.check_word(m_tdata);
        end
    end

    // s_tdata fields from bit 0 up, zero fill on top
    function automatic logic [S_TDATA_W-1:0] pack_event(keyon_event_t ev);
        return {1'b0, ev.reverb_on, ev.pitch_word, ev.voice_number, ev.note_pan,
                ev.program_pan, ev.timbre_pan, ev.seq_scaling_on, ev.seq_right_volume,
                ev.seq_left_volume, ev.tone_volume, ev.program_volume, ev.note_volume};
    endfunction

    // level biased toward the ends and the pan center
    function automatic logic [6:0] pick_level();
        case ($urandom_range(9, 0))
            0: return 7'd0;
            1: return 7'd127;
            2: return 7'(PAN_CENTER - $urandom_range(1, 0));
            default: return 7'($urandom_range(127, 0));
        endcase
    endfunction

    function automatic keyon_event_t random_event();
        keyon_event_t ev;
        ev.note_volume      = pick_level();
        ev.program_volume   = pick_level();
        ev.tone_volume      = pick_level();
        ev.seq_left_volume  = pick_level();
        ev.seq_right_volume = pick_level();
        ev.seq_scaling_on   = ($urandom_range(3, 0) != 0);
        ev.timbre_pan       = pick_level();
        ev.program_pan      = pick_level();
        ev.note_pan         = pick_level();
        if ($urandom_range(9, 0) == 0)
            ev.voice_number = 5'($urandom_range(31, NUM_VOICES));
        else
            ev.voice_number = 5'($urandom_range(NUM_VOICES - 1, 0));
        ev.pitch_word = 16'($urandom);
        ev.reverb_on  = 1'($urandom_range(1, 0));
        return ev;
    endfunction

    function automatic keyon_event_t uniform_event(logic [6:0] level, logic [6:0] pan,
                                                   logic [4:0] voice, logic rev);
        keyon_event_t ev;
        ev.note_volume      = level;
        ev.program_volume   = level;
        ev.tone_volume      = level;
        ev.seq_left_volume  = level;
        ev.seq_right_volume = level;
        ev.seq_scaling_on   = 1'b1;
        ev.timbre_pan       = pan;
        ev.program_pan      = pan;
        ev.note_pan         = pan;
        ev.voice_number     = voice;
        ev.pitch_word       = 16'($urandom);
        ev.reverb_on        = rev;
        return ev;
    endfunction

    // offers one word from a falling edge, valid stays up after acceptance
    task automatic send_event(keyon_event_t ev);
        @(negedge aclk);
        while (src_idle_pct != 0 && $urandom_range(99, 0) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pack_event(ev);
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sb.note_event(ev);
    endtask

    task automatic end_burst();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.pending_q.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_register(idx, value);
    endtask

    task automatic set_mix(logic [6:0] master, logic mono);
        write_register(CFG_MASTER_VOLUME, master);
        write_register(CFG_MONO_MODE, CFG_DATA_W'(mono));
        settings_used++;
    endtask

    task automatic send_edge_events();
        keyon_event_t ev;
        // everything silent, then everything at full scale
        ev = uniform_event(7'd0, 7'd0, 5'd0, 1'b0);
        ev.pitch_word = 16'h0000;
        send_event(ev);
        ev = uniform_event(7'd127, 7'd127, 5'd23, 1'b1);
        ev.pitch_word = 16'hFFFF;
        send_event(ev);
        // pan hard left, just below and at the center
        send_event(uniform_event(7'd127, 7'd0, 5'd1, 1'b1));
        send_event(uniform_event(7'd127, 7'd63, 5'd2, 1'b0));
        send_event(uniform_event(7'd127, 7'd64, 5'd3, 1'b1));
        // pan stages pulling in different directions
        ev = uniform_event(7'd127, 7'd0, 5'd4, 1'b0);
        ev.program_pan = 7'd127;
        ev.note_pan    = 7'd64;
        send_event(ev);
        // sequence scaling off with silent sequence volumes
        ev = uniform_event(7'd100, 7'd64, 5'd6, 1'b1);
        ev.seq_scaling_on   = 1'b0;
        ev.seq_left_volume  = 7'd0;
        ev.seq_right_volume = 7'd0;
        send_event(ev);
        // sequence left only
        ev = uniform_event(7'd127, 7'd64, 5'd7, 1'b1);
        ev.seq_right_volume = 7'd0;
        send_event(ev);
    endtask

    keyon_event_t ev;
    logic [6:0]   master_choice [8];
    logic         mono_choice [8];

    initial begin
        sb = new();
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        cfg_wr_en      = 1'b0;
        cfg_index      = CFG_MASTER_VOLUME;
        cfg_wdata      = '0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_cycles    = 0;
        settings_used  = 1;
        master_choice  = '{7'd127, 7'd0, 7'd64, 7'd127, 7'd1, 7'd0, 7'd127, 7'd90};
        mono_choice    = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed words at reset settings
        send_edge_events();
        // voices past the end, reverb set then cleared on one voice
        send_event(uniform_event(7'd127, 7'd64, 5'd24, 1'b1));
        send_event(uniform_event(7'd127, 7'd64, 5'd31, 1'b1));
        send_event(uniform_event(7'd80, 7'd30, 5'd5, 1'b1));
        send_event(uniform_event(7'd80, 7'd100, 5'd5, 1'b0));
        send_event(uniform_event(7'd127, 7'd127, 5'd0, 1'b1));
        end_burst();
        drain();

        // same edges with master at zero, then mono at full master
        set_mix(7'd0, 1'b1);
        send_edge_events();
        end_burst();
        drain();
        set_mix(7'd127, 1'b1);
        send_edge_events();
        end_burst();
        drain();

        // random phases over settings and idle patterns
        for (int phase = 0; phase < 8; phase++) begin
            set_mix(master_choice[phase], mono_choice[phase]);
            case (phase % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 51; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 51; end
                default: begin src_idle_pct = 6; sink_stall_pct = 6; end
            endcase
            repeat (180) begin
                ev = random_event();
                send_event(ev);
            end
            end_burst();
            drain();
        end

        // long receiver hold-off while the sender keeps offering words
        set_mix(7'($urandom_range(127, 0)), 1'($urandom_range(1, 0)));
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_cycles    = 400;
        repeat (25) begin
            ev = random_event();
            send_event(ev);
        end
        end_burst();
        drain();

        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("ran %0d note-on events under %0d volume/mono settings, %0d results checked",
                 sb.events_seen, settings_used, sb.words_checked);
        $display("phases: no idling, sender gaps, receiver stalls, both, long output hold-off");
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches, %0d results never arrived", sb.errors,
                     sb.pending_q.size());
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
